// ===== src/radial_edge_run_ball_check_defines.svh =====
// ----------------------------------------------------------------------------
// radial_edge_run_ball_check_defines
// Assertion macros shared by the ball check RTL.
// ----------------------------------------------------------------------------
`ifndef RADIAL_EDGE_RUN_BALL_CHECK_DEFINES_SVH
`define RADIAL_EDGE_RUN_BALL_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RERBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RERBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rerbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rerbc_pkg
// Widths, codes and constants of the radial edge-run ball check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rerbc_pkg;

    localparam int PIX_W     = 8;
    localparam int DIST_W    = 9;
    localparam int SCORE_W   = 11;
    localparam int VERDICT_W = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_DIRS  = 3;

    localparam logic [PIX_W-1:0] MAX_BALL_WIDTH = 8'd255;

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [SCORE_W-1:0]   t_score;
    typedef logic [VERDICT_W-1:0] t_verdict;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_verdict VERDICT_SEARCH = 2'd0;
    localparam t_verdict VERDICT_ACCEPT = 2'd1;
    localparam t_verdict VERDICT_GIVEUP = 2'd2;
    localparam t_verdict VERDICT_IDLE   = 2'd3;

    localparam t_cfg_addr CFG_CHANGE_RATIO = 2'd0;
    localparam t_cfg_addr CFG_BLUE_FLOOR   = 2'd1;
    localparam t_cfg_addr CFG_TOLERANCE    = 2'd2;

    localparam t_cfg_data RST_CHANGE_RATIO = 8'd179;
    localparam t_cfg_data RST_BLUE_FLOOR   = 8'd50;
    localparam t_cfg_data RST_TOLERANCE    = 8'd64;

    localparam t_score SCORE_GIVEUP = 11'd1000;

    localparam int DIR_RIGHT = 0;
    localparam int DIR_LEFT  = 1;
    localparam int DIR_UP    = 2;

endpackage

// ===== src/rerbc_chan_if.sv =====
// ----------------------------------------------------------------------------
// rerbc_chan_if
// Valid/ready channels of the ball check: probe words, results, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rerbc_probe_if;
    logic                valid;
    logic                ready;
    logic                first_probe;
    rerbc_pkg::t_pix     center_blue;
    rerbc_pkg::t_pix     ball_size;
    logic                soft_rule;
    rerbc_pkg::t_pix     right_blue;
    rerbc_pkg::t_pix     right_green;
    rerbc_pkg::t_pix     left_blue;
    rerbc_pkg::t_pix     left_green;
    rerbc_pkg::t_pix     up_blue;
    rerbc_pkg::t_pix     up_green;

    modport source (
        output valid, first_probe, center_blue, ball_size, soft_rule,
               right_blue, right_green, left_blue, left_green, up_blue, up_green,
        input  ready
    );
    modport sink (
        input  valid, first_probe, center_blue, ball_size, soft_rule,
               right_blue, right_green, left_blue, left_green, up_blue, up_green,
        output ready
    );
endinterface

interface rerbc_result_if;
    logic                valid;
    logic                ready;
    rerbc_pkg::t_verdict verdict;
    rerbc_pkg::t_score   score;
    logic                run_last;

    modport source (output valid, verdict, score, run_last, input ready);
    modport sink   (input valid, verdict, score, run_last, output ready);
endinterface

interface rerbc_cfg_if;
    logic                 valid;
    logic                 ready;
    rerbc_pkg::t_cfg_addr addr;
    rerbc_pkg::t_cfg_data data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== src/radial_edge_run_ball_check.sv =====
// ----------------------------------------------------------------------------
// radial_edge_run_ball_check
// Each accepted probe word gives one result word, held in the result register.
// Throughput: one probe word per cycle; the single result register takes a
// new word whenever it is empty or its word is taken in the same cycle.
// Reset: synchronous active low; idle (decided), width 1, registers 179/50/64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_edge_run_ball_check_defines.svh"

module radial_edge_run_ball_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rerbc_probe_if.sink   i_probe,
    rerbc_result_if.source o_result,
    rerbc_cfg_if.sink     i_cfg
);
    import rerbc_pkg::*;

    // config
    t_cfg_data r_ratio, r_floor, r_tol;

    // test state
    t_dist           r_dist;
    t_pix            r_prev  [NUM_DIRS];
    t_dist           r_edist [NUM_DIRS];
    logic [NUM_DIRS-1:0] r_found;
    t_pix            r_width;
    logic            r_rule;
    logic            r_decided;

    // result register
    logic            r_out_valid;
    t_verdict        r_verdict;
    t_score          r_score;
    logic            r_last;

    logic            in_acc;

    // selected state (fresh test or running one)
    t_pix            s_w_in, s_w;
    logic            s_rule;
    t_dist           s_dist;
    t_pix            s_prev  [NUM_DIRS];
    t_dist           s_edist [NUM_DIRS];
    logic [NUM_DIRS-1:0] s_found;

    t_pix            blue    [NUM_DIRS];
    t_pix            green   [NUM_DIRS];
    logic [15:0]     prod    [NUM_DIRS];
    logic [8:0]      thr     [NUM_DIRS];
    logic [NUM_DIRS-1:0] hit;

    t_dist           p_edist [NUM_DIRS];
    t_pix            p_prev  [NUM_DIRS];
    logic [NUM_DIRS-1:0] p_found;

    // acceptance terms
    t_dist           half;
    logic [16:0]     tol_t;
    logic            strict_ok, soft_ok, acc_ok;
    logic [9:0]      sum_rl;
    logic [9:0]      dev_rl;
    logic [10:0]     sum_all;
    logic [11:0]     s2, w3, dsc;
    logic [12:0]     dsc_r;

    // next values
    t_dist           n_dist;
    t_pix            n_prev  [NUM_DIRS];
    t_dist           n_edist [NUM_DIRS];
    logic [NUM_DIRS-1:0] n_found;
    t_pix            n_width;
    logic            n_rule;
    logic            n_decided;
    t_verdict        n_verdict;
    t_score          n_score;
    logic            n_last;

    function automatic t_dist absdiff9(input t_dist a, input t_dist b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign i_probe.ready = !r_out_valid || o_result.ready;
    assign in_acc        = i_probe.valid && i_probe.ready;
    assign i_cfg.ready   = 1'b1;

    assign o_result.valid    = r_out_valid;
    assign o_result.verdict  = r_verdict;
    assign o_result.score    = r_score;
    assign o_result.run_last = r_last;

    assign blue[DIR_RIGHT]  = i_probe.right_blue;
    assign green[DIR_RIGHT] = i_probe.right_green;
    assign blue[DIR_LEFT]   = i_probe.left_blue;
    assign green[DIR_LEFT]  = i_probe.left_green;
    assign blue[DIR_UP]     = i_probe.up_blue;
    assign green[DIR_UP]    = i_probe.up_green;

    always_comb begin
        s_w_in = (i_probe.ball_size > MAX_BALL_WIDTH) ? MAX_BALL_WIDTH
                                                      : i_probe.ball_size;
        if (i_probe.first_probe) begin
            s_w    = s_w_in;
            s_rule = i_probe.soft_rule;
            s_dist = 9'd1;
            s_found = '0;
            for (int k = 0; k < NUM_DIRS; k++) begin
                s_prev[k]  = i_probe.center_blue;
                s_edist[k] = '0;
            end
        end else begin
            s_w    = r_width;
            s_rule = r_rule;
            s_dist = r_dist;
            s_found = r_found;
            for (int k = 0; k < NUM_DIRS; k++) begin
                s_prev[k]  = r_prev[k];
                s_edist[k] = r_edist[k];
            end
        end

        // per-direction drop detection
        for (int k = 0; k < NUM_DIRS; k++) begin
            prod[k] = s_prev[k] * r_ratio;
            thr[k]  = 9'((17'(prod[k]) + 17'd128) >> 8);
            hit[k]  = ((9'(blue[k]) < thr[k]) || (blue[k] < r_floor))
                      && !s_found[k] && (green[k] != '0);
            p_found[k] = s_found[k] | hit[k];
            p_edist[k] = hit[k] ? s_dist : s_edist[k];
            p_prev[k]  = hit[k] ? s_prev[k] : blue[k];
        end

        // strict rule
        half  = 9'(s_w >> 1);
        tol_t = 17'(s_w) * 17'(r_tol);
        strict_ok =
            ({absdiff9(p_edist[DIR_RIGHT], half), 8'd0} < tol_t) &&
            ({absdiff9(p_edist[DIR_LEFT], half), 8'd0} < tol_t) &&
            ({absdiff9(p_edist[DIR_UP], half), 8'd0} < (tol_t + 17'd256)) &&
            ({absdiff9(p_edist[DIR_RIGHT], p_edist[DIR_LEFT]), 8'd0} < tol_t);

        // soft rule
        sum_rl = 10'(p_edist[DIR_RIGHT]) + 10'(p_edist[DIR_LEFT]);
        dev_rl = (sum_rl > 10'(s_w)) ? (sum_rl - 10'(s_w)) : (10'(s_w) - sum_rl);
        soft_ok = (dev_rl < 10'(s_w)) &&
                  (p_edist[DIR_UP] > 9'(s_w >> 3)) &&
                  (p_edist[DIR_UP] < 9'(s_w));

        acc_ok = (&p_found) && (s_rule ? soft_ok : strict_ok);

        // score: round-half-up of |1.5 W - sum|
        sum_all = 11'(p_edist[DIR_RIGHT]) + 11'(p_edist[DIR_LEFT])
                + 11'(p_edist[DIR_UP]);
        s2  = {sum_all, 1'b0};
        w3  = 12'({s_w, 1'b0}) + 12'(s_w);
        dsc = (s2 > w3) ? (s2 - w3) : (w3 - s2);
        dsc_r = (13'(dsc) + 13'd1) >> 1;

        n_width   = s_w;
        n_rule    = s_rule;
        n_dist    = s_dist;
        n_found   = s_found;
        n_decided = r_decided;
        for (int k = 0; k < NUM_DIRS; k++) begin
            n_prev[k]  = s_prev[k];
            n_edist[k] = s_edist[k];
        end
        n_verdict = VERDICT_SEARCH;
        n_score   = '0;
        n_last    = 1'b0;

        if (i_probe.first_probe && (s_w == '0)) begin
            n_verdict = VERDICT_GIVEUP;
            n_score   = SCORE_GIVEUP;
            n_last    = 1'b1;
            n_decided = 1'b1;
        end else if (!i_probe.first_probe && r_decided) begin
            n_verdict = VERDICT_IDLE;
        end else begin
            n_found   = p_found;
            n_decided = 1'b0;
            for (int k = 0; k < NUM_DIRS; k++) begin
                n_prev[k]  = p_prev[k];
                n_edist[k] = p_edist[k];
            end
            if (acc_ok) begin
                n_verdict = VERDICT_ACCEPT;
                n_score   = 11'(dsc_r);
                n_last    = 1'b1;
                n_decided = 1'b1;
            end else if ((10'(s_dist) + 10'd1) >= {1'b0, s_w, 1'b0}) begin
                n_verdict = VERDICT_GIVEUP;
                n_score   = SCORE_GIVEUP;
                n_last    = 1'b1;
                n_decided = 1'b1;
            end else begin
                n_dist = s_dist + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RST_CHANGE_RATIO;
            r_floor <= RST_BLUE_FLOOR;
            r_tol   <= RST_TOLERANCE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.addr)
                CFG_CHANGE_RATIO: r_ratio <= i_cfg.data;
                CFG_BLUE_FLOOR:   r_floor <= i_cfg.data;
                CFG_TOLERANCE:    r_tol   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist    <= '0;
            r_found   <= '0;
            r_width   <= 8'd1;
            r_rule    <= 1'b0;
            r_decided <= 1'b1;
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_prev[k]  <= '0;
                r_edist[k] <= '0;
            end
        end else if (in_acc) begin
            r_dist    <= n_dist;
            r_found   <= n_found;
            r_width   <= n_width;
            r_rule    <= n_rule;
            r_decided <= n_decided;
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_prev[k]  <= n_prev[k];
                r_edist[k] <= n_edist[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_verdict <= n_verdict;
            r_score   <= n_score;
            r_last    <= n_last;
        end
    end

    `RERBC_ASSERT_NOW(a_last_ends_test, i_clk, i_rst_n, r_out_valid && r_last, (r_verdict == VERDICT_ACCEPT) || (r_verdict == VERDICT_GIVEUP), "run_last on a word that does not end a test")
    `RERBC_ASSERT_NOW(a_giveup_score, i_clk, i_rst_n, r_out_valid && (r_verdict == VERDICT_GIVEUP), r_score == SCORE_GIVEUP, "give-up word without score 1000")
    `RERBC_ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n, in_acc && n_last, r_decided, "test ended but block not idle")
    `RERBC_ASSERT_NOW(a_running_width, i_clk, i_rst_n, !r_decided, (r_width != '0) && (r_dist != '0), "running test with zero width or distance")
    `RERBC_ASSERT_NOW(a_running_bound, i_clk, i_rst_n, !r_decided, 10'(r_dist) < {1'b0, r_width, 1'b0}, "running test past its give-up distance")

endmodule

// ===== bench/rerbc_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rerbc_verdict_checker
// Watches the probe, result and config channels of the ball check. It keeps
// its own copy of the edge-run state and the registers, and it predicts the
// verdict word for every accepted probe word. Each result word is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module rerbc_verdict_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rerbc_probe_if  i_probe,
    rerbc_result_if i_result,
    rerbc_cfg_if    i_cfg,
    output int      o_mismatch_count,
    output int      o_pending
);

    import rerbc_pkg::*;

    typedef struct packed {
        t_verdict verdict;
        t_score   score;
        logic     run_last;
    } verdict_word_t;

    t_cfg_data drop_ratio_q8;
    t_cfg_data floor_blue;
    t_cfg_data tol_q8;

    t_dist probe_at;
    t_pix  last_blue [NUM_DIRS];
    t_dist edge_at   [NUM_DIRS];
    logic  edge_hit  [NUM_DIRS];
    t_pix  width_q;
    logic  soft_q;
    logic  idle_q;

    verdict_word_t verdicts_due [$];
    int            mismatches = 0;

    function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void follow_dir(int k, t_pix blue, t_pix green);
        int unsigned drop_thr;
        drop_thr = (32'(last_blue[k]) * 32'(drop_ratio_q8) + 128) >> 8;
        if ((blue < drop_thr || blue < floor_blue) && !edge_hit[k] && green != '0) begin
            edge_hit[k] = 1'b1;
            edge_at[k]  = probe_at;
        end else begin
            last_blue[k] = blue;
        end
    endfunction

    function automatic logic ball_fits();
        int unsigned w, er, el, eu, tol;
        w  = width_q;
        er = edge_at[DIR_RIGHT];
        el = edge_at[DIR_LEFT];
        eu = edge_at[DIR_UP];
        if (!(edge_hit[DIR_RIGHT] && edge_hit[DIR_LEFT] && edge_hit[DIR_UP]))
            return 1'b0;
        if (soft_q)
            return abs_gap(er + el, w) < w && eu > w / 8 && eu < w;
        tol = w * tol_q8;
        return abs_gap(er, w / 2) * 256 < tol &&
               abs_gap(el, w / 2) * 256 < tol &&
               abs_gap(eu, w / 2) * 256 < tol + 256 &&
               abs_gap(er, el) * 256 < tol;
    endfunction

    function automatic verdict_word_t predict_verdict();
        verdict_word_t r;
        int unsigned   w, s;
        r = '0;
        if (i_probe.first_probe) begin
            width_q = (i_probe.ball_size > MAX_BALL_WIDTH) ? MAX_BALL_WIDTH
                                                           : i_probe.ball_size;
            soft_q  = i_probe.soft_rule;
            for (int k = 0; k < NUM_DIRS; k++) begin
                last_blue[k] = i_probe.center_blue;
                edge_at[k]   = '0;
                edge_hit[k]  = 1'b0;
            end
            probe_at = t_dist'(1);
            idle_q   = 1'b0;
            if (width_q == '0) begin
                idle_q     = 1'b1;
                r.verdict  = VERDICT_GIVEUP;
                r.score    = SCORE_GIVEUP;
                r.run_last = 1'b1;
                return r;
            end
        end
        if (idle_q) begin
            r.verdict = VERDICT_IDLE;
            return r;
        end
        follow_dir(DIR_RIGHT, i_probe.right_blue, i_probe.right_green);
        follow_dir(DIR_LEFT,  i_probe.left_blue,  i_probe.left_green);
        follow_dir(DIR_UP,    i_probe.up_blue,    i_probe.up_green);
        w = width_q;
        if (ball_fits()) begin
            s = (abs_gap(3 * w, 2 * (32'(edge_at[DIR_RIGHT]) + 32'(edge_at[DIR_LEFT])
                                     + 32'(edge_at[DIR_UP]))) + 1) / 2;
            if (s > 2047)
                s = 2047;
            r.verdict  = VERDICT_ACCEPT;
            r.score    = t_score'(s);
            r.run_last = 1'b1;
            idle_q     = 1'b1;
        end else if (32'(probe_at) + 1 >= 2 * w) begin
            r.verdict  = VERDICT_GIVEUP;
            r.score    = SCORE_GIVEUP;
            r.run_last = 1'b1;
            idle_q     = 1'b1;
        end else begin
            probe_at = probe_at + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        verdict_word_t seen, want, fresh;
        if (!i_rst_n) begin
            drop_ratio_q8 = RST_CHANGE_RATIO;
            floor_blue    = RST_BLUE_FLOOR;
            tol_q8        = RST_TOLERANCE;
            probe_at      = '0;
            for (int k = 0; k < NUM_DIRS; k++) begin
                last_blue[k] = '0;
                edge_at[k]   = '0;
                edge_hit[k]  = 1'b0;
            end
            width_q = t_pix'(1);
            soft_q  = 1'b0;
            idle_q  = 1'b1;
            verdicts_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_CHANGE_RATIO: drop_ratio_q8 = i_cfg.data;
                    CFG_BLUE_FLOOR:   floor_blue    = i_cfg.data;
                    CFG_TOLERANCE:    tol_q8        = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                seen.verdict  = i_result.verdict;
                seen.score    = i_result.score;
                seen.run_last = i_result.run_last;
                if (verdicts_due.size() == 0) begin
                    $error("result word with no probe word pending: verdict %0d score %0d",
                           seen.verdict, seen.score);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (seen.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, seen.verdict);
                        mismatches++;
                    end
                    if (seen.score !== want.score) begin
                        $error("score: expected %0d, got %0d", want.score, seen.score);
                        mismatches++;
                    end
                    if (seen.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, got %0d", want.run_last,
                               seen.run_last);
                        mismatches++;
                    end
                end
            end
            if (i_probe.valid && i_probe.ready) begin
                fresh        = predict_verdict();
                verdicts_due = {verdicts_due, fresh};
            end
        end
        o_mismatch_count <= mismatches;
        o_pending        <= verdicts_due.size();
    end

endmodule

// ===== bench/tb_radial_edge_run_ball_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_edge_run_ball_check
// Drives probe runs into the ball check: a short directed opening, then
// random runs shaped around the ball width under several register settings,
// with bursty probe traffic and a stalling result sink. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_radial_edge_run_ball_check;

    import rerbc_pkg::*;

    localparam int ITEM_TARGET = 800;
    localparam int NUM_PHASES  = 7;
    localparam int CYCLE_LIMIT = 300000;

    logic i_clk;
    logic i_rst_n;
    int   burst_left;
    int   items_sent;
    int   cycle_count;
    int   mismatch_count;
    int   words_pending;

    rerbc_probe_if  probe_ch ();
    rerbc_result_if result_ch ();
    rerbc_cfg_if    cfg_ch ();

    radial_edge_run_ball_check u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_probe  (probe_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    rerbc_verdict_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_probe          (probe_ch),
        .i_result         (result_ch),
        .i_cfg            (cfg_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending        (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result sink: switches among randomly chosen stall styles
    initial begin
        int unsigned style_left, style;
        result_ch.ready <= 1'b0;
        style_left = 0;
        style      = 0;
        forever begin
            @(posedge i_clk);
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(16, 200);
            end
            style_left--;
            case (style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       result_ch.ready <= (style_left % 4 == 0);
                default: result_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_word(input logic is_start, input t_pix cb, input t_pix bw,
                             input logic rule, input t_pix rb, input t_pix rg,
                             input t_pix lb, input t_pix lg, input t_pix ub,
                             input t_pix ug, input bit counts);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                probe_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        probe_ch.valid       <= 1'b1;
        probe_ch.first_probe <= is_start;
        probe_ch.center_blue <= cb;
        probe_ch.ball_size   <= bw;
        probe_ch.soft_rule   <= rule;
        probe_ch.right_blue  <= rb;
        probe_ch.right_green <= rg;
        probe_ch.left_blue   <= lb;
        probe_ch.left_green  <= lg;
        probe_ch.up_blue     <= ub;
        probe_ch.up_green    <= ug;
        do @(posedge i_clk); while (!probe_ch.ready);
        burst_left--;
        if (counts)
            items_sent++;
    endtask

    task automatic drain_results();
        probe_ch.valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (3) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic load_settings(input t_cfg_data ratio, input t_cfg_data floor_val,
                                 input t_cfg_data tol);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= CFG_CHANGE_RATIO;
        cfg_ch.data  <= ratio;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.addr  <= CFG_BLUE_FLOOR;
        cfg_ch.data  <= floor_val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.addr  <= CFG_TOLERANCE;
        cfg_ch.data  <= tol;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // one test: blue climbs until the planned edge distance, then drops
    task automatic run_ball_test();
        int   w, len, pick, spread, deepest;
        int   edge_d   [NUM_DIRS];
        t_pix run_blue [NUM_DIRS];
        t_pix blue     [NUM_DIRS];
        t_pix green    [NUM_DIRS];
        t_pix cb;
        logic rule, scramble;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            w = 0;
        else if (pick < 8)
            w = $urandom_range(100, 255);
        else if (pick < 15)
            w = $urandom_range(1, 2);
        else
            w = $urandom_range(3, 40);
        rule     = $urandom_range(0, 1);
        cb       = t_pix'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(60, 255));
        scramble = ($urandom_range(0, 9) == 0);
        spread   = w / 8 + 1;
        deepest  = 1;
        for (int k = 0; k < NUM_DIRS; k++) begin
            if (rule && k == DIR_UP)
                edge_d[k] = $urandom_range(w / 8 + 1, w + 1);
            else
                edge_d[k] = w / 2 + int'($urandom_range(0, 2 * spread)) - spread;
            if (edge_d[k] < 1)
                edge_d[k] = 1;
            if (edge_d[k] > deepest)
                deepest = edge_d[k];
            run_blue[k] = cb;
        end
        pick = $urandom_range(0, 99);
        if (w == 0) begin
            len = $urandom_range(1, 3);
        end else if (pick < 60) begin
            len = deepest + $urandom_range(0, 1);
        end else if (pick < 85) begin
            // keep one direction from dropping so the run goes the full distance
            len = 2 * w - 1;
            edge_d[$urandom_range(0, 2)] = 2 * w + 1;
        end else begin
            len = $urandom_range(1, deepest);
        end
        for (int d = 1; d <= len; d++) begin
            for (int k = 0; k < NUM_DIRS; k++) begin
                if (scramble || d > edge_d[k]) begin
                    blue[k]  = t_pix'($urandom_range(0, 255));
                    green[k] = t_pix'($urandom_range(0, 255));
                end else if (d < edge_d[k]) begin
                    blue[k]     = t_pix'($urandom_range(run_blue[k], 255));
                    run_blue[k] = blue[k];
                    green[k]    = t_pix'($urandom_range(0, 255));
                end else begin
                    blue[k]  = t_pix'($urandom_range(0, 24));
                    green[k] = t_pix'($urandom_range(1, 255));
                end
            end
            send_word(d == 1, cb, t_pix'(w), rule,
                      blue[DIR_RIGHT], green[DIR_RIGHT], blue[DIR_LEFT], green[DIR_LEFT],
                      blue[DIR_UP], green[DIR_UP], d <= ((w == 0) ? 1 : 2 * w - 1));
        end
    endtask

    initial begin
        int pick;
        i_rst_n              <= 1'b0;
        probe_ch.valid       <= 1'b0;
        probe_ch.first_probe <= 1'b0;
        probe_ch.center_blue <= '0;
        probe_ch.ball_size   <= '0;
        probe_ch.soft_rule   <= 1'b0;
        probe_ch.right_blue  <= '0;
        probe_ch.right_green <= '0;
        probe_ch.left_blue   <= '0;
        probe_ch.left_green  <= '0;
        probe_ch.up_blue     <= '0;
        probe_ch.up_green    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.addr          <= CFG_CHANGE_RATIO;
        cfg_ch.data          <= '0;
        burst_left = 0;
        items_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle after reset, zero width, width one
        send_word(0,   0,   0, 0,   0,   0,   0,   0,   0,   0, 0);
        send_word(0, 255, 255, 1, 255, 255, 255, 255, 255, 255, 0);
        send_word(1, 255,   0, 1, 255, 255, 255, 255, 255, 255, 1);
        send_word(0,   0,   0, 0,   7,   7,   7,   7,   7,   7, 0);
        send_word(1, 200,   1, 0,  10, 255,  10, 255,  10, 255, 1);
        // strict accept, all edges at two
        send_word(1, 200,   4, 0, 200, 255, 200, 255, 200, 255, 1);
        send_word(0,   0,   0, 0,  10, 255,  10, 255,  10, 255, 1);
        // soft accept; zero green hides a drop, floor edge, found direction
        send_word(1, 255,   8, 1, 255,   0, 255,   0, 255,   0, 1);
        send_word(0,   0,   0, 0,   0,   0, 255,   1, 255,   1, 1);
        send_word(0,   0,   0, 0,  49,   7, 255, 255, 100,   1, 1);
        send_word(0,   0,   0, 0,   0,   0, 177,   9,   0,   0, 1);
        // widest ball, then restart mid-run into a strict accept
        send_word(1, 128, 255, 1,  90,   3, 200,   0, 128,  64, 1);
        send_word(0,   0,   0, 0, 130,   0,  60,  60, 130,   2, 1);
        send_word(1,  90,   6, 0,  90,   1,  90,   1,  90,   1, 1);
        send_word(0,   0,   0, 0,  62,   1,  90,   1, 255, 128, 1);
        send_word(0,   0,   0, 0,   0, 255,   0, 255,  30,   1, 1);
        send_word(0, 255, 255, 1, 255, 255, 255, 255, 255, 255, 0);
        send_word(1,   0, 255, 0,   0, 255,   0, 255,   0, 255, 1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                case (p)
                    1: load_settings(8'd0, 8'd0, 8'd0);
                    2: load_settings(8'd255, 8'd255, 8'd255);
                    3: load_settings(RST_CHANGE_RATIO, RST_BLUE_FLOOR, RST_TOLERANCE);
                    default: load_settings(t_cfg_data'($urandom_range(100, 255)),
                                           t_cfg_data'($urandom_range(0, 120)),
                                           t_cfg_data'($urandom_range(8, 255)));
                endcase
            end
            while (items_sent < (p + 1) * ITEM_TARGET / NUM_PHASES) begin
                run_ball_test();
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    drain_results();
                end else if (pick < 3) begin
                    repeat ($urandom_range(1, 3))
                        send_word(0, t_pix'($urandom_range(0, 255)),
                                  t_pix'($urandom_range(0, 255)), $urandom_range(0, 1),
                                  t_pix'($urandom_range(0, 255)), t_pix'($urandom_range(0, 255)),
                                  t_pix'($urandom_range(0, 255)), t_pix'($urandom_range(0, 255)),
                                  t_pix'($urandom_range(0, 255)), t_pix'($urandom_range(0, 255)),
                                  0);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("** radial_edge_run_ball_check: PASSED **");
        else
            $display("** radial_edge_run_ball_check: FAILED **");
        $finish;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timed out after %0d cycles, %0d result words outstanding",
               cycle_count, words_pending);
        $display("** radial_edge_run_ball_check: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rerbc_pkg.sv
src/rerbc_chan_if.sv
src/radial_edge_run_ball_check.sv
bench/rerbc_verdict_checker.sv
bench/tb_radial_edge_run_ball_check.sv
